>>> src/pcmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcmf_pkg
// Shared constants and types for the PCM to float channel mapper.
// ----------------------------------------------------------------------------
package pcmf_pkg;
	localparam int RAW_W   = 24;
	localparam int FLOAT_W = 32;
	localparam int CH_W    = 3;
	localparam int CNT_W   = 4;
	localparam int IDX_W   = 2;
	localparam int STORE_DEPTH = 8;

	localparam logic [IDX_W-1:0] REG_SAMPLE_BYTES  = 2'd0;
	localparam logic [IDX_W-1:0] REG_FILE_CHANNELS = 2'd1;
	localparam logic [IDX_W-1:0] REG_DEV_CHANNELS  = 2'd2;

	typedef struct packed {
		logic [RAW_W-1:0] raw_sample;
		logic             missing;
	} in_item_t;

	typedef struct packed {
		logic [FLOAT_W-1:0] float_bits;
		logic [CH_W-1:0]    out_channel;
		logic               last_in_frame;
	} out_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic [7:0]       data;
	} cfg_item_t;

	// converter control between sequencer and normalizer
	typedef struct packed {
		logic       start;
		logic       wide;
	} cvt_ctl_t;
endpackage
`default_nettype wire

>>> src/pcmf_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcmf_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface pcmf_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> src/pcmf_norm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcmf_norm
// Iterative int-to-float converter: one shared shifter, one bit per cycle.
// ----------------------------------------------------------------------------
module pcmf_norm
	import pcmf_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cvt_ctl_t           ctl,
	input  wire logic [RAW_W-1:0]   raw,
	input  wire logic               missing,
	output logic                    done,
	output logic [FLOAT_W-1:0]      result
);
	logic [RAW_W-1:0] mag_q;
	logic [7:0]       expo_q;
	logic             neg_q;
	logic             busy_q;
	logic             zero_q;
	logic [RAW_W-1:0] sext;
	logic [RAW_W-1:0] mag_in;

	always_comb begin
		sext = ctl.wide ? raw : {{8{raw[15]}}, raw[15:0]};
		mag_in = sext[RAW_W-1] ? (~sext + 24'd1) : sext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
		end else if (busy_q && (zero_q || mag_q[RAW_W-1])) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			neg_q  <= sext[RAW_W-1] && !missing;
			mag_q  <= mag_in;
			zero_q <= missing || (mag_in == '0);
			// value = mag * 2^-s; top at bit 23 gives exponent 23+127-s
			expo_q <= ctl.wide ? 8'd127 : 8'd135;
		end else if (busy_q && !zero_q && !mag_q[RAW_W-1]) begin
			mag_q  <= {mag_q[RAW_W-2:0], 1'b0};
			expo_q <= expo_q - 8'd1;
		end
	end

	assign done = busy_q && (zero_q || mag_q[RAW_W-1]);
	assign result = zero_q ? '0 : {neg_q, expo_q, mag_q[RAW_W-2:0]};
endmodule
`default_nettype wire

>>> src/pcm_to_float_channel_mapper_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_to_float_channel_mapper_top
// PCM sample to IEEE single converter with per-frame channel mapping.
// ----------------------------------------------------------------------------
// Each sample transfer is converted by a shift-one-bit-per-cycle normalizer,
// which shifts out the leading zeros; the result is written to the frame store.
// When the last file channel arrives, one word per device channel leaves one
// per cycle from the store read port unless the output stalls; the input is not ready meanwhile.
module pcm_to_float_channel_mapper_top
	import pcmf_pkg::*;
#(
	parameter int MAX_CHANNELS = 8
)(
	input  wire logic clk,
	input  wire logic arst_n,
	pcmf_if.sink      cfg,
	pcmf_if.sink      in_ch,
	pcmf_if.source    out_ch
);
	localparam int LIM = (MAX_CHANNELS < STORE_DEPTH) ? MAX_CHANNELS : STORE_DEPTH;
	localparam logic [CNT_W-1:0] LIM_C = CNT_W'(LIM);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CVT  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]       state_q;
	logic [1:0]       sample_bytes_q;
	logic [CNT_W-1:0] file_channels_q, dev_channels_q;
	logic [CH_W-1:0]  channel_count_q;
	logic [CNT_W-1:0] emit_q;
	logic [FLOAT_W-1:0] store_q [STORE_DEPTH];
	logic             out_valid_q;
	out_item_t        out_q;
	logic [CNT_W-1:0] fc, oc;
	cvt_ctl_t         ctl;
	logic             done;
	logic [FLOAT_W-1:0] result;
	logic [CNT_W-1:0] src;
	in_item_t         in_item;
	cfg_item_t        cfg_item;

	assign in_item  = in_ch.payload;
	assign cfg_item = cfg.payload;

	always_comb begin
		fc = (file_channels_q == '0) ? 4'd1 :
			(file_channels_q > LIM_C) ? LIM_C : file_channels_q;
		oc = (dev_channels_q == '0) ? 4'd1 :
			(dev_channels_q > LIM_C) ? LIM_C : dev_channels_q;
		src = (emit_q < fc) ? emit_q : fc - 4'd1;
	end

	assign cfg.ready   = 1'b1;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign ctl.start   = in_ch.valid && in_ch.ready;
	assign ctl.wide    = (sample_bytes_q == 2'd3);

	pcmf_norm u_norm (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.raw     (in_item.raw_sample),
		.missing (in_item.missing),
		.done    (done),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_bytes_q  <= 2'd2;
			file_channels_q <= 4'd2;
			dev_channels_q  <= 4'd2;
		end else if (cfg.valid) begin
			case (cfg_item.index)
				REG_SAMPLE_BYTES:  sample_bytes_q  <= cfg_item.data[1:0];
				REG_FILE_CHANNELS: file_channels_q <= cfg_item.data[3:0];
				REG_DEV_CHANNELS:  dev_channels_q  <= cfg_item.data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CVT && done) begin
			store_q[channel_count_q] <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			channel_count_q <= '0;
			emit_q          <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && (!out_valid_q || out_ch.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (ctl.start) begin
						state_q <= ST_CVT;
					end
				end
				ST_CVT: begin
					if (done) begin
						if ({1'b0, channel_count_q} + 4'd1 < fc) begin
							channel_count_q <= channel_count_q + 3'd1;
							state_q <= ST_IDLE;
						end else begin
							channel_count_q <= '0;
							emit_q <= '0;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || out_ch.ready) begin
						emit_q <= emit_q + 4'd1;
						if (emit_q + 4'd1 == oc) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && (!out_valid_q || out_ch.ready)) begin
			out_q.float_bits    <= store_q[src[CH_W-1:0]];
			out_q.out_channel   <= emit_q[CH_W-1:0];
			out_q.last_in_frame <= (emit_q + 4'd1 == oc);
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = out_q;
endmodule
`default_nettype wire

>>> sim/pcmf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmf_checker
// Watches the config, sample and float channels of the channel mapper,
// predicts each output word from the accepted samples and compares them in
// order. Reports the number of failures to the testbench top.
// ----------------------------------------------------------------------------
module pcmf_checker
	import pcmf_pkg::*;
#(
	parameter int MAX_CHANNELS = 8
)(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_valid,
	input  wire logic cfg_ready,
	input  cfg_item_t cfg_payload,
	input  wire logic in_valid,
	input  wire logic in_ready,
	input  in_item_t  in_payload,
	input  wire logic out_valid,
	input  wire logic out_ready,
	input  out_item_t out_payload,
	output int        errors,
	output int        pending
);
	localparam int CH_LIMIT = (MAX_CHANNELS < STORE_DEPTH) ? MAX_CHANNELS : STORE_DEPTH;

	logic [1:0]         width_sel;
	logic [CNT_W-1:0]   file_ch;
	logic [CNT_W-1:0]   dev_ch;
	logic [FLOAT_W-1:0] frame_words [STORE_DEPTH];
	logic [CH_W-1:0]    fill_idx;
	out_item_t          expected_words [$];

	assign pending = expected_words.size();

	function automatic int clamp_channels(input logic [CNT_W-1:0] n);
		if (n == 0)
			return 1;
		if (n > CH_LIMIT)
			return CH_LIMIT;
		return n;
	endfunction

	function automatic logic [FLOAT_W-1:0] pcm_to_single(input in_item_t s,
		input logic [1:0] sel);
		logic        neg;
		logic [24:0] mag;
		int          top;
		int          shift;
		logic [FLOAT_W-1:0] bits;
		if (s.missing)
			return '0;
		if (sel == 2'd3) begin
			neg = s.raw_sample[23];
			mag = neg ? (25'h1000000 - s.raw_sample) : {1'b0, s.raw_sample};
			shift = 23;
		end else begin
			neg = s.raw_sample[15];
			mag = neg ? (25'h10000 - s.raw_sample[15:0]) : {9'd0, s.raw_sample[15:0]};
			shift = 15;
		end
		if (mag == 0)
			return '0;
		top = 0;
		for (int i = 0; i < 25; i++)
			if (mag[i])
				top = i;
		bits[31] = neg;
		bits[30:23] = 8'(top + 127 - shift);
		bits[22:0] = 23'(mag << (23 - top));
		return bits;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int fc;
		int oc;
		int src;
		out_item_t w;
		out_item_t got;
		if (!arst_n) begin
			width_sel <= 2'd2;
			file_ch <= 4'd2;
			dev_ch <= 4'd2;
			fill_idx = '0;
			errors <= 0;
			expected_words.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_payload.index)
				REG_SAMPLE_BYTES: width_sel <= cfg_payload.data[1:0];
				REG_FILE_CHANNELS: file_ch <= cfg_payload.data[3:0];
				REG_DEV_CHANNELS: dev_ch <= cfg_payload.data[3:0];
				default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				fc = clamp_channels(file_ch);
				oc = clamp_channels(dev_ch);
				frame_words[fill_idx] = pcm_to_single(in_payload, width_sel);
				if (fill_idx + 1 < fc) begin
					fill_idx = fill_idx + 1'b1;
				end else begin
					fill_idx = '0;
					for (int c = 0; c < oc; c++) begin
						src = (c < fc) ? c : fc - 1;
						w.float_bits = frame_words[src];
						w.out_channel = CH_W'(c);
						w.last_in_frame = (c + 1 == oc);
						expected_words.push_back(w);
					end
				end
			end
			if (out_valid && out_ready) begin
				got = out_payload;
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual %h/%0d/%0d",
						$time, got.float_bits, got.out_channel, got.last_in_frame);
					errors <= errors + 1;
				end else begin
					w = expected_words.pop_front();
					if (got !== w) begin
						$display("%0t: mismatch, expected %h/%0d/%0d, actual %h/%0d/%0d",
							$time, w.float_bits, w.out_channel, w.last_in_frame,
							got.float_bits, got.out_channel, got.last_in_frame);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives PCM samples through the channel mapper across sample widths and
// channel counts, with bursty input and a stalling output, and reports the
// checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
	import pcmf_pkg::*;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   cycles;
	bit   hold_off;
	bit   stall_on;

	pcmf_if #(.payload_t(cfg_item_t)) cfg ();
	pcmf_if #(.payload_t(in_item_t))  in_ch ();
	pcmf_if #(.payload_t(out_item_t)) out_ch ();

	pcm_to_float_channel_mapper_top uut (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .in_ch(in_ch), .out_ch(out_ch)
	);

	pcmf_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg.valid), .cfg_ready(cfg.ready), .cfg_payload(cfg.payload),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_payload(in_ch.payload),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_payload(out_ch.payload),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// receiver: random stall pattern, plus one long hold-off
	initial begin
		int n;
		out_ch.ready = 0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				n = 300;
				out_ch.ready <= 0;
				repeat (n) @(posedge clk);
				hold_off = 0;
			end
			if (!stall_on)
				out_ch.ready <= 1;
			else
				out_ch.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// valid stays high between consecutive register writes
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [7:0] val);
		cfg.valid <= 1;
		cfg.payload <= '{index: idx, data: val};
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
	endtask

	task automatic configure(input logic [7:0] sb, input logic [7:0] fc, input logic [7:0] oc);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		write_reg(REG_SAMPLE_BYTES, sb);
		write_reg(REG_FILE_CHANNELS, fc);
		write_reg(REG_DEV_CHANNELS, oc);
		cfg.valid <= 0;
	endtask

	// one transfer; valid stays high between back-to-back samples
	task automatic send_sample(input logic [23:0] raw, input logic miss, input bit gap_after);
		in_ch.valid <= 1;
		in_ch.payload <= '{raw_sample: raw, missing: miss};
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		if (gap_after) begin
			in_ch.valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic random_frames(input int count);
		int burst;
		logic [23:0] raw;
		for (int i = 0; i < count; i++) begin
			burst = (burst > 0) ? burst - 1 : $urandom_range(0, 12);
			case ($urandom_range(0, 5))
			0: raw = 24'h800000 ^ 24'($urandom_range(0, 3));
			1: raw = 24'h7FFFFF ^ 24'($urandom_range(0, 3));
			2: raw = 24'($urandom_range(0, 15));
			default: raw = 24'($urandom);
			endcase
			send_sample(raw, $urandom_range(0, 9) == 0, burst == 0);
		end
		in_ch.valid <= 0;
	endtask

	initial begin
		logic [23:0] edge_vals [10] = '{24'h000000, 24'h000001, 24'h007FFF, 24'h008000,
			24'h00FFFF, 24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'hABCDEF, 24'h12FFFF};
		arst_n = 0;
		hold_off = 0;
		stall_on = 0;
		cfg.valid = 0;
		cfg.payload = '0;
		in_ch.valid = 0;
		in_ch.payload = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset settings, then 24-bit, then odd widths and zero counts
		foreach (edge_vals[i])
			send_sample(edge_vals[i], 0, 0);
		send_sample(24'h123456, 1, 1);
		send_sample(24'h000000, 0, 1);
		in_ch.valid <= 0;
		configure(3, 3, 8);
		foreach (edge_vals[i])
			send_sample(edge_vals[i], i == 4, 0);
		send_sample(24'h400000, 0, 1);
		in_ch.valid <= 0;
		configure(0, 0, 0);
		send_sample(24'h008000, 0, 1);
		configure(1, 15, 15);
		for (int i = 0; i < 8; i++)
			send_sample(24'h000100 << i, 0, 0);
		in_ch.valid <= 0;
		// count shrunk mid-frame
		configure(3, 8, 3);
		send_sample(24'h000005, 0, 1);
		send_sample(24'hFFFFF0, 0, 1);
		send_sample(24'h0000FF, 0, 1);
		in_ch.valid <= 0;
		configure(3, 2, 3);
		send_sample(24'h800001, 0, 1);
		in_ch.valid <= 0;

		// random part across several settings
		stall_on = 1;
		configure(2, 8, 1);
		hold_off = 1;
		random_frames(30);
		configure(3, 1, 8);
		random_frames(25);
		configure(8'($urandom_range(0, 3)), 8'($urandom_range(0, 15)),
			8'($urandom_range(0, 15)));
		random_frames(30);
		configure(3, 4, 6);
		random_frames(25);
		configure(2, 5, 2);
		random_frames(25);

		while (pending != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
